@@ hdl/integer_literal_parser_macros.svh @@
// ----------------------------------------------------------------------------
// Integer literal parser assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_LITERAL_PARSER_MACROS_SVH
`define INTEGER_LITERAL_PARSER_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ILP_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("integer_literal_parser: check failed");

// Consequent holds in the cycle after the antecedent.
`define ILP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("integer_literal_parser: check failed");

`endif

@@ hdl/ilp_pkg.sv @@
// ----------------------------------------------------------------------------
// Integer literal parser package
// Character codes, register indexes and the character class type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilp_pkg;

   localparam int CSR_DATA_WIDTH = 64;

   localparam logic CSR_POS_LIMIT = 1'b0;
   localparam logic CSR_NEG_LIMIT = 1'b1;

   localparam logic [CSR_DATA_WIDTH-1:0] POS_LIMIT_RESET = 64'd4294967295;
   localparam logic [CSR_DATA_WIDTH-1:0] NEG_LIMIT_RESET = 64'd2147483648;

   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_0          = 8'h30;
   localparam logic [7:0] CHAR_9          = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F    = 8'h46;

   localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

   typedef struct packed {
      logic       is_minus;
      logic       is_plus;
      logic       is_underscore;
      logic       digit_valid;
      logic [3:0] digit;
   } char_class_type;

endpackage

@@ hdl/ilp_char_decode.sv @@
// ----------------------------------------------------------------------------
// Integer literal parser character decoder
// Classifies one character: sign, underscore, or digit of the token's base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilp_char_decode
   import ilp_pkg::*;
(
   input  logic [7:0]     char_in,
   input  logic           is_hex,
   output char_class_type cls
);

   logic       is_dec_digit;
   logic       is_lower_hex;
   logic       is_upper_hex;
   logic [7:0] dec_value;
   logic [7:0] lower_value;
   logic [7:0] upper_value;

   assign is_dec_digit = (char_in >= CHAR_0) && (char_in <= CHAR_9);
   assign is_lower_hex = is_hex && (char_in >= CHAR_LOWER_A) && (char_in <= CHAR_LOWER_F);
   assign is_upper_hex = is_hex && (char_in >= CHAR_UPPER_A) && (char_in <= CHAR_UPPER_F);

   assign dec_value   = char_in - CHAR_0;
   assign lower_value = char_in - CHAR_LOWER_A + HEX_LETTER_BASE;
   assign upper_value = char_in - CHAR_UPPER_A + HEX_LETTER_BASE;

   always_comb begin
      cls.is_minus      = (char_in == CHAR_MINUS);
      cls.is_plus       = (char_in == CHAR_PLUS);
      cls.is_underscore = (char_in == CHAR_UNDERSCORE);
      cls.digit_valid   = is_dec_digit || is_lower_hex || is_upper_hex;
      if (is_dec_digit) begin
         cls.digit = dec_value[3:0];
      end else if (is_lower_hex) begin
         cls.digit = lower_value[3:0];
      end else begin
         cls.digit = upper_value[3:0];
      end
   end

endmodule

@@ hdl/ilp_accum.sv @@
// ----------------------------------------------------------------------------
// Integer literal parser accumulator
// Token state machine with saturating multiply-add of base 10 or 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilp_accum
   import ilp_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  char_class_type         cls,
   input  logic                   is_hex,
   input  logic                   last,
   input  logic [VALUE_WIDTH-1:0] pos_limit,
   input  logic [VALUE_WIDTH-1:0] neg_limit,
   output logic [VALUE_WIDTH-1:0] value,
   output logic                   too_large
);

   typedef enum logic [1:0] {
      PH_SIGN,
      PH_PFX0,
      PH_PFX1,
      PH_DIGITS
   } phase_type;

   phase_type              phase_ff, phase_in, phase_next;
   logic [VALUE_WIDTH-1:0] accum_ff, accum_in, accum_next;
   logic                   negative_ff, negative_in, negative_next;
   logic                   overflowed_ff, overflowed_in, overflowed_next;

   logic                   digit_phase;
   logic                   take;
   logic [VALUE_WIDTH-1:0] limit;
   logic [VALUE_WIDTH+3:0] product;
   logic [VALUE_WIDTH+4:0] sum;
   logic                   over;

   // limit follows the sign as it stands before this word
   assign limit = negative_ff ? neg_limit : pos_limit;

   // accum * 10 as (accum << 3) + (accum << 1), accum * 16 as a shift
   assign product = is_hex ? {accum_ff, 4'b0000}
                           : ({1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0});
   assign sum  = {1'b0, product} + (VALUE_WIDTH + 5)'(cls.digit);
   assign over = sum > {5'b00000, limit};

   always_comb begin
      digit_phase = 1'b0;
      phase_next  = phase_ff;
      negative_next = negative_ff;
      unique case (phase_ff)
         PH_SIGN: begin
            if (cls.is_minus || cls.is_plus) begin
               negative_next = negative_ff || cls.is_minus;
               phase_next    = is_hex ? PH_PFX0 : PH_DIGITS;
            end else if (is_hex) begin
               phase_next = PH_PFX1;
            end else begin
               phase_next  = PH_DIGITS;
               digit_phase = 1'b1;
            end
         end
         PH_PFX0: phase_next = PH_PFX1;
         PH_PFX1: phase_next = PH_DIGITS;
         PH_DIGITS: digit_phase = 1'b1;
         default: phase_next = PH_SIGN;
      endcase

      take = digit_phase && cls.digit_valid && !cls.is_underscore && !overflowed_ff;
      accum_next      = accum_ff;
      overflowed_next = overflowed_ff;
      if (take) begin
         if (over) begin
            accum_next      = limit;
            overflowed_next = 1'b1;
         end else begin
            accum_next = sum[VALUE_WIDTH-1:0];
         end
      end
   end

   // result of the word just stepped; clear the token once last is taken
   assign value     = negative_next ? VALUE_WIDTH'(~accum_next + 1'b1) : accum_next;
   assign too_large = overflowed_next;

   always_comb begin
      phase_in      = phase_ff;
      accum_in      = accum_ff;
      negative_in   = negative_ff;
      overflowed_in = overflowed_ff;
      if (step) begin
         if (last) begin
            phase_in      = PH_SIGN;
            accum_in      = '0;
            negative_in   = 1'b0;
            overflowed_in = 1'b0;
         end else begin
            phase_in      = phase_next;
            accum_in      = accum_next;
            negative_in   = negative_next;
            overflowed_in = overflowed_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIGN;
         accum_ff      <= '0;
         negative_ff   <= 1'b0;
         overflowed_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         accum_ff      <= accum_in;
         negative_ff   <= negative_in;
         overflowed_ff <= overflowed_in;
      end
   end

endmodule

@@ hdl/integer_literal_parser.sv @@
// ----------------------------------------------------------------------------
// Integer literal parser: one character a word, one value word per token.
// Result: registered as the last character word of a token leaves the input register.
// Throughput: one character a cycle, set by the accumulator multiply-add loop; a last
// word waits in the input register only while the previous value word is unread.
// Reset: synchronous; clears token state and limits to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_literal_parser
   import ilp_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_char_in,
   input  logic                      req_is_hex,
   input  logic                      req_last,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [VALUE_WIDTH-1:0]    rsp_value,
   output logic                      rsp_too_large,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [7:0]             s1_char_ff;
   logic                   s1_hex_ff;
   logic                   s1_last_ff;
   logic                   advance;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic                   rsp_too_large_ff;

   logic [VALUE_WIDTH-1:0] pos_limit_ff, pos_limit_in;
   logic [VALUE_WIDTH-1:0] neg_limit_ff, neg_limit_in;

   char_class_type         cls;
   logic [VALUE_WIDTH-1:0] step_value;
   logic                   step_too_large;

   // a last word waits only while a finished result is still held
   assign advance     = s1_valid_ff && !(s1_last_ff && rsp_valid_ff && !rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !advance);

   assign csr_ready = 1'b1;

   always_comb begin
      pos_limit_in = pos_limit_ff;
      neg_limit_in = neg_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_POS_LIMIT: pos_limit_in = csr_wdata[VALUE_WIDTH-1:0];
            CSR_NEG_LIMIT: neg_limit_in = csr_wdata[VALUE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   ilp_char_decode u_decode (
      .char_in (s1_char_ff),
      .is_hex  (s1_hex_ff),
      .cls     (cls)
   );

   ilp_accum #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .cls       (cls),
      .is_hex    (s1_hex_ff),
      .last      (s1_last_ff),
      .pos_limit (pos_limit_ff),
      .neg_limit (neg_limit_ff),
      .value     (step_value),
      .too_large (step_too_large)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_limit_ff <= POS_LIMIT_RESET[VALUE_WIDTH-1:0];
         neg_limit_ff <= NEG_LIMIT_RESET[VALUE_WIDTH-1:0];
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_limit_ff <= pos_limit_in;
         neg_limit_ff <= neg_limit_in;
      end
   end

   // payload registers: input fields load on acceptance, the result on a last word's advance; hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_char_in;
         s1_hex_ff  <= req_is_hex;
         s1_last_ff <= req_last;
      end
      if (advance && s1_last_ff) begin
         rsp_value_ff     <= step_value;
         rsp_too_large_ff <= step_too_large;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_too_large = rsp_too_large_ff;

endmodule

@@ hdl/ilp_checker.sv @@
// ----------------------------------------------------------------------------
// Integer literal parser port checker
// Watches the top-level ports for result holding, reset and flow behaviour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_literal_parser_macros.svh"

module ilp_checker #(
   parameter int VALUE_WIDTH = 64
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [VALUE_WIDTH-1:0] rsp_value,
   input logic                   rsp_too_large
);

   // a stalled result word holds
   `ILP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `ILP_ASSERT_NEXT(a_value_stable, rsp_valid && !rsp_ready, $stable(rsp_value))
   `ILP_ASSERT_NEXT(a_flag_stable, rsp_valid && !rsp_ready, $stable(rsp_too_large))

   // no result straight out of reset
   `ILP_ASSERT_ALWAYS(a_reset_empty, !$past(reset) || !rsp_valid)

   // input never backs up while the output side is free
   `ILP_ASSERT_ALWAYS(a_input_flows, (rsp_valid && !rsp_ready) || req_ready)

endmodule

bind integer_literal_parser ilp_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_checker (.*);
